// ===== src/ndpp_pkg.sv =====
`default_nettype none

package ndpp_pkg;

    // width of the op counter
    localparam int COUNT_WIDTH = 16;
    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

    // queue between parser and record emitter
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [7:0]             byte_t;
    typedef logic [4:0]             kind_t;
    typedef logic [31:0]            len_t;
    typedef logic [15:0]            cap_t;
    typedef logic [15:0]            ocount_t;
    typedef logic [COUNT_WIDTH-1:0] ops_t;
    typedef logic [QPTR_W-1:0]      qptr_t;
    typedef logic [QCNT_W-1:0]      qcnt_t;

    // script opcodes
    localparam byte_t MARK_NULLDATA = 8'h6a;
    localparam byte_t OPC_LEN1      = 8'h4c;
    localparam byte_t OPC_LEN2      = 8'h4d;
    localparam byte_t OPC_LEN4      = 8'h4e;
    localparam byte_t OPC_SMALL_LO  = 8'h4f;
    localparam byte_t OPC_SMALL_HI  = 8'h60;

    // op kind codes in records
    localparam kind_t KIND_IMMEDIATE  = 5'd0;
    localparam kind_t KIND_PUSHDATA1  = 5'd1;
    localparam kind_t KIND_PUSHDATA2  = 5'd2;
    localparam kind_t KIND_PUSHDATA4  = 5'd3;
    localparam kind_t KIND_SMALL_BASE = 5'd4;

    localparam logic REC_OP  = 1'b0;
    localparam logic REC_END = 1'b1;

    // results caused by one input beat
    typedef struct packed {
        logic    has_op;
        kind_t   op_kind;
        len_t    push_length;
        logic    has_end;
        logic    is_null_data;
        ocount_t op_count;
    } entry_t;

    // queue status toward the parser
    typedef struct packed {
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

// ===== src/ndpp_ifs.sv =====
`default_nettype none

interface ndpp_in_if;
    logic               valid;
    logic               ready;
    ndpp_pkg::byte_t    script_byte;
    logic               byte_present;
    logic               last_byte;

    modport source (output valid, script_byte, byte_present, last_byte, input ready);
    modport sink   (input valid, script_byte, byte_present, last_byte, output ready);
endinterface

interface ndpp_out_if;
    logic               valid;
    logic               ready;
    logic               record_type;
    ndpp_pkg::kind_t    op_kind;
    ndpp_pkg::len_t     push_length;
    logic               is_null_data;
    ndpp_pkg::ocount_t  op_count;
    logic               last_record;

    modport source (output valid, record_type, op_kind, push_length, is_null_data,
                    op_count, last_record, input ready);
    modport sink   (input valid, record_type, op_kind, push_length, is_null_data,
                    op_count, last_record, output ready);
endinterface

interface ndpp_cfg_if;
    logic               valid;
    logic               ready;
    ndpp_pkg::cap_t     op_capacity;

    modport source (output valid, op_capacity, input ready);
    modport sink   (input valid, op_capacity, output ready);
endinterface

`default_nettype wire

// ===== src/ndpp_front.sv =====
`default_nettype none

module ndpp_front (
    input  wire             clk,
    input  wire             rst_n,
    ndpp_in_if.sink         script_in,
    ndpp_cfg_if.sink        cfg_wr,
    input  ndpp_pkg::qstat_t qstat,
    output logic            push,
    output ndpp_pkg::entry_t push_entry
);
    import ndpp_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_OPCODE,
        PH_LEN,
        PH_SKIP,
        PH_DRAIN
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] lbl_reg, lbl_next;
    kind_t      kind_reg, kind_next;
    len_t       skip_reg, skip_next;
    ops_t       ops_reg, ops_next;
    cap_t       cap_reg;

    logic        accept;
    byte_t       b;
    logic [31:0] cap_lim;
    logic        ops_full;
    logic [2:0]  total;
    logic [1:0]  pos;
    entry_t      ent;

    assign cfg_wr.ready    = 1'b1;
    assign script_in.ready = !qstat.full;
    assign accept          = script_in.valid && !qstat.full;
    assign b               = script_in.script_byte;

    // capacity is the smaller of the register and the counter range
    assign cap_lim  = ({16'b0, cap_reg} < 32'(COUNT_MAX)) ? {16'b0, cap_reg}
                                                          : 32'(COUNT_MAX);
    assign ops_full = 32'(ops_reg) >= cap_lim;

    // byte position of the next length byte
    assign total = (kind_reg == KIND_PUSHDATA4) ? 3'd4 : 3'(kind_reg);
    assign pos   = 2'(total - lbl_reg);

    // parse step for one beat
    always_comb
    begin
        phase_next = phase_reg;
        lbl_next   = lbl_reg;
        kind_next  = kind_reg;
        skip_next  = skip_reg;
        ops_next   = ops_reg;
        ent        = '0;

        if (accept && script_in.byte_present)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    phase_next = (b == MARK_NULLDATA) ? PH_OPCODE : PH_DRAIN;
                end
                PH_OPCODE:
                begin
                    if (ops_full || b > OPC_SMALL_HI)
                    begin
                        phase_next = PH_DRAIN;
                    end
                    else if (b < OPC_LEN1)
                    begin
                        ent.has_op      = 1'b1;
                        ent.op_kind     = KIND_IMMEDIATE;
                        ent.push_length = 32'(b);
                        ops_next        = ops_reg + 1'b1;
                        skip_next       = 32'(b);
                        phase_next      = (b != 8'd0) ? PH_SKIP : PH_OPCODE;
                    end
                    else if (b < OPC_SMALL_LO)
                    begin
                        kind_next  = 5'(b - OPC_LEN1) + KIND_PUSHDATA1;
                        lbl_next   = (b == OPC_LEN4) ? 3'd4
                                                     : 3'(b - OPC_LEN1) + 3'd1;
                        skip_next  = '0;
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        ent.has_op  = 1'b1;
                        ent.op_kind = 5'(b - OPC_SMALL_LO) + KIND_SMALL_BASE;
                        ops_next    = ops_reg + 1'b1;
                    end
                end
                PH_LEN:
                begin
                    skip_next = skip_reg | (32'(b) << {pos, 3'b000});
                    lbl_next  = lbl_reg - 3'd1;
                    if (lbl_next == 3'd0)
                    begin
                        ent.has_op      = 1'b1;
                        ent.op_kind     = kind_reg;
                        ent.push_length = skip_next;
                        ops_next        = ops_reg + 1'b1;
                        phase_next      = (skip_next != '0) ? PH_SKIP : PH_OPCODE;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_OPCODE;
                    end
                end
                PH_DRAIN:
                begin
                    phase_next = PH_DRAIN;
                end
                default:
                begin
                    phase_next = PH_DRAIN;
                end
            endcase
        end

        // end of script summary and clear
        if (accept && script_in.last_byte)
        begin
            ent.has_end      = 1'b1;
            ent.is_null_data = (phase_next == PH_OPCODE);
            ent.op_count     = (phase_next == PH_OPCODE) ? 16'(ops_next) : '0;
            phase_next       = PH_FIRST;
            lbl_next         = '0;
            kind_next        = '0;
            skip_next        = '0;
            ops_next         = '0;
        end
    end

    assign push       = accept && (ent.has_op || ent.has_end);
    assign push_entry = ent;

    // parser state and capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            lbl_reg   <= '0;
            kind_reg  <= '0;
            skip_reg  <= '0;
            ops_reg   <= '0;
            cap_reg   <= 16'hffff;
        end
        else
        begin
            phase_reg <= phase_next;
            lbl_reg   <= lbl_next;
            kind_reg  <= kind_next;
            skip_reg  <= skip_next;
            ops_reg   <= ops_next;
            if (cfg_wr.valid)
            begin
                cap_reg <= cfg_wr.op_capacity;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ndpp_queue.sv =====
`default_nettype none

module ndpp_queue (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               push,
    input  ndpp_pkg::entry_t  push_entry,
    output ndpp_pkg::qstat_t  qstat,
    input  wire               pop,
    output logic              head_valid,
    output ndpp_pkg::entry_t  head_entry
);
    import ndpp_pkg::*;

    entry_t mem_reg [QDEPTH];
    qptr_t  wr_ptr_reg, wr_ptr_next;
    qptr_t  rd_ptr_reg, rd_ptr_next;
    qcnt_t  cnt_reg, cnt_next;
    logic   do_pop;

    assign qstat.full = (cnt_reg == qcnt_t'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == qptr_t'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == qptr_t'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/ndpp_back.sv =====
`default_nettype none

module ndpp_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              head_valid,
    input  ndpp_pkg::entry_t head_entry,
    output logic             pop,
    ndpp_out_if.source       record_out
);
    import ndpp_pkg::*;

    logic    out_valid_reg;
    logic    rec_type_reg;
    kind_t   kind_reg;
    len_t    len_reg;
    logic    null_reg;
    ocount_t count_reg;
    logic    last_reg;

    // summary still owed after an op record
    logic    pend_end_reg;
    logic    pend_null_reg;
    ocount_t pend_count_reg;

    logic    can_load;

    assign can_load = !out_valid_reg || record_out.ready;
    assign pop      = can_load && !pend_end_reg && head_valid;

    assign record_out.valid        = out_valid_reg;
    assign record_out.record_type  = rec_type_reg;
    assign record_out.op_kind      = kind_reg;
    assign record_out.push_length  = len_reg;
    assign record_out.is_null_data = null_reg;
    assign record_out.op_count     = count_reg;
    assign record_out.last_record  = last_reg;

    // control: output valid and pending summary
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
        end
        else if (can_load)
        begin
            if (pend_end_reg)
            begin
                out_valid_reg <= 1'b1;
                pend_end_reg  <= 1'b0;
            end
            else if (head_valid)
            begin
                out_valid_reg <= 1'b1;
                pend_end_reg  <= head_entry.has_op && head_entry.has_end;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            if (pend_end_reg)
            begin
                rec_type_reg <= REC_END;
                kind_reg     <= '0;
                len_reg      <= '0;
                null_reg     <= pend_null_reg;
                count_reg    <= pend_count_reg;
                last_reg     <= 1'b1;
            end
            else if (head_valid)
            begin
                pend_null_reg  <= head_entry.is_null_data;
                pend_count_reg <= head_entry.op_count;
                if (head_entry.has_op)
                begin
                    rec_type_reg <= REC_OP;
                    kind_reg     <= head_entry.op_kind;
                    len_reg      <= head_entry.push_length;
                    null_reg     <= 1'b0;
                    count_reg    <= '0;
                    last_reg     <= !head_entry.has_end;
                end
                else
                begin
                    rec_type_reg <= REC_END;
                    kind_reg     <= '0;
                    len_reg      <= '0;
                    null_reg     <= head_entry.is_null_data;
                    count_reg    <= head_entry.op_count;
                    last_reg     <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/nulldata_script_push_parser.sv =====
// Null-data output script push parser.
// script_in carries one script byte per beat (byte_present, last_byte marks
// the final beat; an empty script is one beat with no byte and last_byte set).
// record_out gives one op record per push op once its length is known, and a
// summary record after the last beat with is_null_data and op_count.
// last_record is set on the final record caused by an input beat.
// cfg_wr writes op_capacity (reset 65535); write only while the block is idle.
// Throughput: one input beat per cycle while script_in.ready is high; a beat
// that causes both an op record and the summary gives the op record first.
// The first record of a beat is registered into the four-entry queue and then
// into the output register, and a record_out stall can hold it in between;
// the parser classifies the beat in its accept cycle.
// When record_out stalls the queue fills and script_in.ready drops once it
// holds four entries; nothing is dropped. Reset clears the parser state, the
// queue and the output register, and sets op_capacity to 65535.
`default_nettype none

module nulldata_script_push_parser (
    input  wire         clk,
    input  wire         rst_n,
    ndpp_in_if.sink     script_in,
    ndpp_cfg_if.sink    cfg_wr,
    ndpp_out_if.source  record_out
);
    import ndpp_pkg::*;

    qstat_t qstat;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   head_valid;
    entry_t head_entry;

    // parser: accepts and classifies beats
    ndpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .script_in  (script_in),
        .cfg_wr     (cfg_wr),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // queue between parser and emitter
    ndpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .qstat      (qstat),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // emitter: serializes records onto the output
    ndpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .record_out (record_out)
    );

endmodule

`default_nettype wire
